FILE: design/cgard_pkg.sv
// cgard_pkg: shared constants, result codes and controller/datapath bundles
// for the cga rle image decoder; no dependencies
`default_nettype none

package cgard_pkg;

  // geometry limits
  localparam int MAX_ROW_BYTES = 128;
  localparam int MIN_ROW_BYTES = 8;
  localparam int MAX_ROWS      = 512;

  // stream header layout
  localparam int HDR_LEN     = 5;
  localparam int MAX_MARKERS = 4;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int ROW_BYTES_W = 8;
  localparam int ROW_CNT_W  = 10;
  localparam int COL_W      = 7;
  localparam int HDR_W      = 3;
  localparam int MCNT_W     = 3;
  localparam int SLOT_W     = 16;
  localparam int RUN_W      = 8;
  localparam int PAIR_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // register reset values
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 8'd80;
  localparam logic [ROW_CNT_W-1:0]   ROW_CNT_RESET   = 10'd200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_SEGMENT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CORRUPT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd2;

  // what the controller does after taking an item
  localparam logic [1:0] ACT_IDLE = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_STAT = 2'd2;

  typedef struct packed {
    logic load;      // input item taken this cycle
    logic step;      // advance the run by one segment
    logic stat;      // status result goes out this cycle
    logic out_load;  // output register takes a new result
  } cmd_t;

  typedef struct packed {
    logic [1:0] next_act;   // decoded from the offered item
    logic       step_emit;  // the pending step writes a segment
    logic       step_done;  // the pending step ends the run
    logic       end_flag;   // the item being worked on ends the stream
  } sts_t;

endpackage

`default_nettype wire

FILE: design/cgard_ctrl.sv
// cgard_ctrl: handshake and sequencing state machine of the decoder
// depends on cgard_pkg
`default_nettype none

module cgard_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  cgard_pkg::sts_t    sts,
  output cgard_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_STAT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load     = in_valid && (state_r == S_IDLE);
    cmd.step     = (state_r == S_RUN) && (!sts.step_emit || out_free);
    cmd.stat     = (state_r == S_STAT) && out_free;
    cmd.out_load = (cmd.step && sts.step_emit) || cmd.stat;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          unique case (sts.next_act)
            cgard_pkg::ACT_RUN:  state_nxt = S_RUN;
            cgard_pkg::ACT_STAT: state_nxt = S_STAT;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_RUN: begin
        if (cmd.step && sts.step_done) begin
          state_nxt = sts.end_flag ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (cmd.stat) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/cgard_dp.sv
// cgard_dp: decoder datapath (registers, header and marker store, run
// segmenter, slot address and output register); depends on cgard_pkg
`default_nettype none

module cgard_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [cgard_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cgard_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [cgard_pkg::BYTE_W-1:0]      in_stream_byte,
  input  wire logic                              in_stream_end,
  input  cgard_pkg::cmd_t                        cmd,
  output cgard_pkg::sts_t                        sts,
  output logic [cgard_pkg::STATUS_W-1:0]         out_status,
  output logic [cgard_pkg::SLOT_W-1:0]           out_first_slot,
  output logic                                   out_backward,
  output logic [cgard_pkg::RUN_W-1:0]            out_run_length,
  output logic [cgard_pkg::PAIR_W-1:0]           out_high_pair,
  output logic [cgard_pkg::PAIR_W-1:0]           out_low_pair,
  output logic                                   out_last_result
);

  localparam int PROD_W = cgard_pkg::ROW_CNT_W + cgard_pkg::ROW_BYTES_W;

  // configuration
  logic [cgard_pkg::ROW_BYTES_W-1:0] row_bytes_r, row_bytes_nxt;
  logic [cgard_pkg::ROW_CNT_W-1:0]   row_count_r, row_count_nxt;

  // stream state
  logic [cgard_pkg::HDR_W-1:0]  hdr_pos_r, hdr_pos_nxt;
  logic [cgard_pkg::MCNT_W-1:0] mcount_r, mcount_nxt;
  logic [cgard_pkg::BYTE_W-1:0] marker_r [cgard_pkg::MAX_MARKERS];
  logic [cgard_pkg::BYTE_W-1:0] marker_nxt [cgard_pkg::MAX_MARKERS];
  logic                         await_r, await_nxt;
  logic [cgard_pkg::BYTE_W-1:0] held_r, held_nxt;
  logic [cgard_pkg::ROW_CNT_W-1:0] row_r, row_nxt;
  logic [cgard_pkg::COL_W-1:0]  col_r, col_nxt;
  logic                         full_r, full_nxt;
  logic                         bad_r, bad_nxt;

  // run in progress
  logic [cgard_pkg::RUN_W-1:0]    n_r, n_nxt;
  logic [cgard_pkg::BYTE_W-1:0]   v_r, v_nxt;
  logic                           lit_r, lit_nxt;
  logic                           end_r, end_nxt;
  logic [cgard_pkg::STATUS_W-1:0] stat_code_r, stat_code_nxt;

  // output register
  logic [cgard_pkg::STATUS_W-1:0] o_status_r;
  logic [cgard_pkg::SLOT_W-1:0]   o_slot_r;
  logic                           o_back_r;
  logic [cgard_pkg::RUN_W-1:0]    o_len_r;
  logic [cgard_pkg::PAIR_W-1:0]   o_hi_r;
  logic [cgard_pkg::PAIR_W-1:0]   o_lo_r;
  logic                           o_last_r;

  logic [cgard_pkg::ROW_BYTES_W-1:0] rb_eff;
  logic [cgard_pkg::ROW_CNT_W-1:0]   rows_eff;

  logic                              wrap_pre, pre_full, wrap_post, full_post;
  logic [cgard_pkg::COL_W-1:0]       c_pre, col_post;
  logic [cgard_pkg::ROW_CNT_W-1:0]   r_pre, r_post;
  logic [cgard_pkg::ROW_BYTES_W-1:0] rem, col_sum, off;
  logic [cgard_pkg::RUN_W-1:0]       seg, n_left;
  logic [PROD_W-1:0]                 prod, slot_sum;
  logic                              match, done, hdr_err, rearm;
  logic [cgard_pkg::HDR_W-1:0]       pos_m1;

  // saturated geometry
  always_comb begin
    if (row_bytes_r < cgard_pkg::ROW_BYTES_W'(cgard_pkg::MIN_ROW_BYTES)) begin
      rb_eff = cgard_pkg::ROW_BYTES_W'(cgard_pkg::MIN_ROW_BYTES);
    end else if (row_bytes_r > cgard_pkg::ROW_BYTES_W'(cgard_pkg::MAX_ROW_BYTES)) begin
      rb_eff = cgard_pkg::ROW_BYTES_W'(cgard_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = row_bytes_r;
    end
    if (row_count_r == '0) begin
      rows_eff = cgard_pkg::ROW_CNT_W'(1);
    end else if (row_count_r > cgard_pkg::ROW_CNT_W'(cgard_pkg::MAX_ROWS)) begin
      rows_eff = cgard_pkg::ROW_CNT_W'(cgard_pkg::MAX_ROWS);
    end else begin
      rows_eff = row_count_r;
    end
  end

  // one segment of the current run: at most up to the end of the row
  always_comb begin
    // column may sit past the row end if the width shrank
    wrap_pre  = {1'b0, col_r} >= rb_eff;
    c_pre     = wrap_pre ? '0 : col_r;
    r_pre     = wrap_pre ? row_r + 1'b1 : row_r;
    pre_full  = r_pre >= rows_eff;
    rem       = rb_eff - {1'b0, c_pre};
    seg       = (rem < n_r) ? rem : n_r;
    col_sum   = {1'b0, c_pre} + seg;
    wrap_post = col_sum >= rb_eff;
    r_post    = wrap_post ? r_pre + 1'b1 : r_pre;
    full_post = wrap_post && (r_post >= rows_eff);
    col_post  = wrap_post ? '0 : col_sum[cgard_pkg::COL_W-1:0];
    n_left    = n_r - seg;
    done      = pre_full || (n_left == '0) || full_post;
    // odd rows run right to left
    off       = r_pre[0] ? (rb_eff - 1'b1 - {1'b0, c_pre}) : {1'b0, c_pre};
    prod      = {{cgard_pkg::ROW_BYTES_W{1'b0}}, r_pre} *
                {{cgard_pkg::ROW_CNT_W{1'b0}}, rb_eff};
    slot_sum  = prod + {{cgard_pkg::ROW_CNT_W{1'b0}}, off};
  end

  always_comb begin
    match = 1'b0;
    for (int k = 0; k < cgard_pkg::MAX_MARKERS; k++) begin
      if ((cgard_pkg::MCNT_W'(k) < mcount_r) && (marker_r[k] == v_r)) begin
        match = 1'b1;
      end
    end
  end

  // decode of the offered item
  assign hdr_err = (hdr_pos_r == '0) &&
                   (in_stream_byte > cgard_pkg::BYTE_W'(cgard_pkg::MAX_MARKERS));

  always_comb begin
    if (bad_r) begin
      sts.next_act = cgard_pkg::ACT_IDLE;
    end else if (hdr_pos_r < cgard_pkg::HDR_W'(cgard_pkg::HDR_LEN)) begin
      sts.next_act = (hdr_err || in_stream_end) ? cgard_pkg::ACT_STAT : cgard_pkg::ACT_IDLE;
    end else if (full_r) begin
      sts.next_act = in_stream_end ? cgard_pkg::ACT_STAT : cgard_pkg::ACT_IDLE;
    end else if (await_r && (in_stream_byte <= cgard_pkg::BYTE_W'(1))) begin
      sts.next_act = in_stream_end ? cgard_pkg::ACT_STAT : cgard_pkg::ACT_IDLE;
    end else begin
      sts.next_act = cgard_pkg::ACT_RUN;
    end
    sts.step_emit = !pre_full;
    sts.step_done = done;
    sts.end_flag  = end_r;
  end

  assign pos_m1 = hdr_pos_r - 1'b1;
  assign rearm  = (cmd.load && bad_r && in_stream_end) || (cmd.stat && end_r);

  always_comb begin
    row_bytes_nxt = row_bytes_r;
    row_count_nxt = row_count_r;
    hdr_pos_nxt   = hdr_pos_r;
    mcount_nxt    = mcount_r;
    marker_nxt    = marker_r;
    await_nxt     = await_r;
    held_nxt      = held_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    full_nxt      = full_r;
    bad_nxt       = bad_r;
    n_nxt         = n_r;
    v_nxt         = v_r;
    lit_nxt       = lit_r;
    end_nxt       = end_r;
    stat_code_nxt = stat_code_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        cgard_pkg::CFG_ROW_BYTES: row_bytes_nxt = cfg_data[cgard_pkg::ROW_BYTES_W-1:0];
        cgard_pkg::CFG_ROW_COUNT: row_count_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.load && !bad_r) begin
      end_nxt = in_stream_end;
      if (hdr_pos_r < cgard_pkg::HDR_W'(cgard_pkg::HDR_LEN)) begin
        stat_code_nxt = cgard_pkg::ST_CORRUPT;
        if (hdr_pos_r == '0) begin
          mcount_nxt = in_stream_byte[cgard_pkg::MCNT_W-1:0];
          if (hdr_err) begin
            bad_nxt = 1'b1;
          end
        end else begin
          marker_nxt[pos_m1[1:0]] = in_stream_byte;
        end
        hdr_pos_nxt = hdr_pos_r + 1'b1;
      end else begin
        stat_code_nxt = cgard_pkg::ST_FINISHED;
        if (!full_r) begin
          if (await_r) begin
            await_nxt = 1'b0;
            n_nxt     = in_stream_byte - 1'b1;
            v_nxt     = held_r;
            lit_nxt   = 1'b0;
          end else begin
            n_nxt   = cgard_pkg::RUN_W'(1);
            v_nxt   = in_stream_byte;
            lit_nxt = 1'b1;
          end
        end
      end
    end

    if (cmd.step) begin
      if (pre_full) begin
        full_nxt = 1'b1;
        row_nxt  = r_pre;
        col_nxt  = c_pre;
      end else begin
        row_nxt  = r_post;
        col_nxt  = col_post;
        full_nxt = full_post;
        n_nxt    = n_left;
        // a literal that matches a live marker waits for its repeat count
        if (done && lit_r && !full_post && !end_r && match) begin
          await_nxt = 1'b1;
          held_nxt  = v_r;
        end
      end
    end

    if (rearm) begin
      hdr_pos_nxt = '0;
      mcount_nxt  = '0;
      await_nxt   = 1'b0;
      held_nxt    = '0;
      row_nxt     = '0;
      col_nxt     = '0;
      full_nxt    = 1'b0;
      bad_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= cgard_pkg::ROW_BYTES_RESET;
      row_count_r <= cgard_pkg::ROW_CNT_RESET;
      hdr_pos_r   <= '0;
      mcount_r    <= '0;
      await_r     <= 1'b0;
      held_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      full_r      <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      row_bytes_r <= row_bytes_nxt;
      row_count_r <= row_count_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      mcount_r    <= mcount_nxt;
      await_r     <= await_nxt;
      held_r      <= held_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      full_r      <= full_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    marker_r    <= marker_nxt;
    n_r         <= n_nxt;
    v_r         <= v_nxt;
    lit_r       <= lit_nxt;
    end_r       <= end_nxt;
    stat_code_r <= stat_code_nxt;
    if (cmd.out_load) begin
      if (cmd.stat) begin
        o_status_r <= stat_code_r;
        o_slot_r   <= '0;
        o_back_r   <= 1'b0;
        o_len_r    <= '0;
        o_hi_r     <= '0;
        o_lo_r     <= '0;
        o_last_r   <= 1'b1;
      end else begin
        o_status_r <= cgard_pkg::ST_SEGMENT;
        o_slot_r   <= slot_sum[cgard_pkg::SLOT_W-1:0];
        o_back_r   <= r_pre[0];
        o_len_r    <= seg;
        o_hi_r     <= {v_r[7:6], 2'b00, v_r[5:4]};
        o_lo_r     <= {v_r[3:2], 2'b00, v_r[1:0]};
        o_last_r   <= done && !end_r;
      end
    end
  end

  assign out_status      = o_status_r;
  assign out_first_slot  = o_slot_r;
  assign out_backward    = o_back_r;
  assign out_run_length  = o_len_r;
  assign out_high_pair   = o_hi_r;
  assign out_low_pair    = o_lo_r;
  assign out_last_result = o_last_r;

endmodule

`default_nettype wire

FILE: design/cga_rle_image_decoder.sv
// cga_rle_image_decoder: top level, joins the controller and the datapath
// depends on cgard_pkg, cgard_ctrl, cgard_dp
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    stream_byte, stream_end
//   out      output     out_valid / out_ready  status, first_slot, backward,
//                                              run_length, high_pair, low_pair,
//                                              last_result
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item is taken in the idle state; header bytes, bytes after an error, bytes past
// a full frame and repeat counts of zero or one end there. a literal takes one step
// and a longer repeat one step per row segment (at least one); a status result adds a
// step. a result waits in the output register while the next item is taken, and a
// segment or status step stalls while it is held. cfg_ready is always high. synchronous
// reset restores the registers and the stream.
`default_nettype none

module cga_rle_image_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [cgard_pkg::BYTE_W-1:0]      in_stream_byte,
  input  wire logic                              in_stream_end,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [cgard_pkg::STATUS_W-1:0]         out_status,
  output logic [cgard_pkg::SLOT_W-1:0]           out_first_slot,
  output logic                                   out_backward,
  output logic [cgard_pkg::RUN_W-1:0]            out_run_length,
  output logic [cgard_pkg::PAIR_W-1:0]           out_high_pair,
  output logic [cgard_pkg::PAIR_W-1:0]           out_low_pair,
  output logic                                   out_last_result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cgard_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cgard_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cgard_pkg::cmd_t cmd;
  cgard_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cgard_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cgard_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_stream_byte  (in_stream_byte),
    .in_stream_end   (in_stream_end),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_first_slot  (out_first_slot),
    .out_backward    (out_backward),
    .out_run_length  (out_run_length),
    .out_high_pair   (out_high_pair),
    .out_low_pair    (out_low_pair),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking testbench for cga_rle_image_decoder, streams compressed picture bytes
// and checks every write segment and status item against an in-bench decoder
// depends on cgard_pkg and the cga_rle_image_decoder rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgard_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 9;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } stream_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   first_slot;
    logic                backward;
    logic [RUN_W-1:0]    run_length;
    logic [PAIR_W-1:0]   high_pair;
    logic [PAIR_W-1:0]   low_pair;
    logic                last_result;
  } frame_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] in_stream_byte = '0;
  logic in_stream_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0] out_first_slot;
  logic out_backward;
  logic [RUN_W-1:0] out_run_length;
  logic [PAIR_W-1:0] out_high_pair;
  logic [PAIR_W-1:0] out_low_pair;
  logic out_last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cga_rle_image_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .in_stream_end  (in_stream_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_first_slot (out_first_slot),
    .out_backward   (out_backward),
    .out_run_length (out_run_length),
    .out_high_pair  (out_high_pair),
    .out_low_pair   (out_low_pair),
    .out_last_result(out_last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  stream_item_t stream_q[$];
  frame_write_t segment_q[$];
  stream_item_t drive_item;
  frame_write_t want;
  bit in_taken = 1'b0;
  int idle_pct = 20;
  int errors = 0;
  int quiet = 0;

  // decoder copy: geometry registers and stream state
  logic [ROW_BYTES_W-1:0] rb_reg = ROW_BYTES_RESET;
  logic [ROW_CNT_W-1:0] rows_reg = ROW_CNT_RESET;
  int unsigned hdr_idx = 0;
  logic [BYTE_W-1:0] marker_n = '0;
  logic [BYTE_W-1:0] markers[MAX_MARKERS];
  bit repeat_pending = 1'b0;
  logic [BYTE_W-1:0] repeat_byte = '0;
  int unsigned pic_row = 0;
  int unsigned pic_col = 0;
  bit frame_done = 1'b0;
  bit stream_err = 1'b0;

  function automatic void rearm_stream();
    hdr_idx = 0;
    marker_n = '0;
    repeat_pending = 1'b0;
    repeat_byte = '0;
    pic_row = 0;
    pic_col = 0;
    frame_done = 1'b0;
    stream_err = 1'b0;
  endfunction

  function automatic void add_result(logic [STATUS_W-1:0] st, int unsigned slot, bit back,
                                     int unsigned len, logic [BYTE_W-1:0] v);
    frame_write_t r;
    r.status = st;
    r.first_slot = slot[SLOT_W-1:0];
    r.backward = back;
    r.run_length = len[RUN_W-1:0];
    r.high_pair = {v[7:6], 2'b00, v[5:4]};
    r.low_pair = {v[3:2], 2'b00, v[1:0]};
    r.last_result = 1'b0;
    segment_q.push_back(r);
  endfunction

  // split a run of n copies into row segments, odd rows run right to left
  function automatic void paint_run(logic [BYTE_W-1:0] v, int unsigned n);
    int unsigned rb, rows, seg, slot;
    bit odd;
    rb = (rb_reg < MIN_ROW_BYTES) ? MIN_ROW_BYTES :
         (rb_reg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : rb_reg;
    rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    while (n > 0 && !frame_done) begin
      if (pic_col >= rb) begin
        pic_col = 0;
        pic_row++;
      end
      if (pic_row >= rows) begin
        frame_done = 1'b1;
        break;
      end
      seg = (rb - pic_col < n) ? rb - pic_col : n;
      odd = pic_row[0];
      slot = pic_row * rb + (odd ? rb - 1 - pic_col : pic_col);
      add_result(ST_SEGMENT, slot, odd, seg, v);
      pic_col += seg;
      n -= seg;
      if (pic_col >= rb) begin
        pic_col = 0;
        pic_row++;
        if (pic_row >= rows) frame_done = 1'b1;
      end
    end
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b, logic fin);
    int unsigned before_n, k;
    frame_write_t tail;
    before_n = segment_q.size();
    if (stream_err) begin
      if (fin) rearm_stream();
    end else if (hdr_idx < HDR_LEN) begin
      if (hdr_idx == 0) begin
        marker_n = b;
        if (b > MAX_MARKERS) begin
          stream_err = 1'b1;
          add_result(ST_CORRUPT, 0, 1'b0, 0, '0);
        end
      end else begin
        markers[hdr_idx - 1] = b;
      end
      hdr_idx++;
      if (fin) begin
        if (!stream_err) add_result(ST_CORRUPT, 0, 1'b0, 0, '0);
        rearm_stream();
      end
    end else begin
      if (!frame_done) begin
        if (repeat_pending) begin
          repeat_pending = 1'b0;
          if (b > 1) paint_run(repeat_byte, b - 1);
        end else begin
          paint_run(b, 1);
          if (!frame_done && !fin) begin
            for (k = 0; k < marker_n && k < MAX_MARKERS; k++) begin
              if (markers[k] == b) begin
                repeat_pending = 1'b1;
                repeat_byte = b;
                break;
              end
            end
          end
        end
      end
      if (fin) begin
        add_result(ST_FINISHED, 0, 1'b0, 0, '0);
        rearm_stream();
      end
    end
    if (segment_q.size() > before_n) begin
      tail = segment_q.pop_back();
      tail.last_result = 1'b1;
      segment_q.push_back(tail);
    end
  endfunction

  function automatic void check_field(string what, logic [SLOT_W-1:0] exp_v,
                                      logic [SLOT_W-1:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] v, logic e);
    stream_q.push_back('{data: v, last: e});
  endfunction

  function automatic logic [BYTE_W-1:0] pick_repeat();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 20) return 8'($urandom_range(1));
    if (p < 60) return 8'($urandom_range(12, 2));
    if (p < 80) return 8'($urandom_range(64, 13));
    return 8'($urandom_range(255, 65));
  endfunction

  // one compressed stream; returns the number of bytes the block acts on
  function automatic int add_stream(bit close);
    int unsigned mode, n_mk, len, i, k;
    logic [BYTE_W-1:0] mk[MAX_MARKERS];
    logic [BYTE_W-1:0] v;
    bit rep;
    mode = $urandom_range(99);
    if (mode < 8) begin
      // oversized marker count, the tail is skipped
      push_byte(8'($urandom_range(255, MAX_MARKERS + 1)), 1'b0);
      len = $urandom_range(3);
      for (i = 0; i < len; i++) push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b1);
      return 1;
    end
    if (mode < 16) begin
      // stream ends inside the header
      len = $urandom_range(HDR_LEN - 1);
      for (i = 0; i <= len; i++) begin
        v = (i == 0) ? 8'($urandom_range(7)) : 8'($urandom);
        push_byte(v, i == len);
      end
      return len + 1;
    end
    n_mk = $urandom_range(MAX_MARKERS);
    push_byte(8'(n_mk), 1'b0);
    for (k = 0; k < MAX_MARKERS; k++) begin
      mk[k] = 8'($urandom);
      push_byte(mk[k], 1'b0);
    end
    len = $urandom_range(24, 1);
    i = 0;
    while (i < len) begin
      rep = 1'b0;
      if (n_mk > 0 && $urandom_range(99) < 40) begin
        v = mk[$urandom_range(n_mk - 1)];
        rep = 1'b1;
      end else if ($urandom_range(99) < 10) begin
        v = mk[$urandom_range(MAX_MARKERS - 1)];
      end else begin
        v = 8'($urandom);
      end
      i++;
      push_byte(v, close && i == len);
      if (rep && i < len) begin
        i++;
        push_byte(pick_repeat(), close && i == len);
      end
    end
    return HDR_LEN + len;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ROW_BYTES) rb_reg = val[ROW_BYTES_W-1:0];
    else rows_reg = val[ROW_CNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (stream_q.size() != 0 || in_valid || segment_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stream driver
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (stream_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drive_item = stream_q.pop_front();
        in_valid <= 1'b1;
        in_stream_byte <= drive_item.data;
        in_stream_end <= drive_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (in_valid && in_ready) begin
        decode_byte(in_stream_byte, in_stream_end);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (segment_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected item, status %0d slot %0d run %0d", $time,
                   out_status, out_first_slot, out_run_length);
        end else begin
          want = segment_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("first_slot", want.first_slot, out_first_slot);
          check_field("backward", want.backward, out_backward);
          check_field("run_length", want.run_length, out_run_length);
          check_field("high_pair", want.high_pair, out_high_pair);
          check_field("low_pair", want.low_pair, out_low_pair);
          check_field("last_result", want.last_result, out_last_result);
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    logic [ROW_BYTES_W-1:0] rb_pick;
    logic [ROW_CNT_W-1:0] rows_pick;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // marker count too large, then bytes and an end that must stay silent
    push_byte(8'd5, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hFF, 1'b1);
    // bad count on a one-byte stream reports once; plain one-byte stream
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    // header cut short
    push_byte(8'd2, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);
    // full header, repeat counts zero, one and max, marker as the last byte
    push_byte(8'd4, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h1B, 1'b0);
    push_byte(8'hC3, 1'b1);
    drain_and_settle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          rb_pick = '0;
          rows_pick = '0;
        end
        1: begin
          rb_pick = '1;
          rows_pick = '1;
        end
        2: begin
          rb_pick = 8'(MIN_ROW_BYTES);
          rows_pick = 10'd2;
        end
        3: begin
          rb_pick = 8'(MAX_ROW_BYTES);
          rows_pick = 10'd1;
        end
        default: begin
          rb_pick = ($urandom_range(99) < 80) ? 8'($urandom_range(20, 8)) : 8'($urandom);
          rows_pick = ($urandom_range(99) < 70) ? 10'($urandom_range(4, 1))
                                                : 10'($urandom);
        end
      endcase
      write_reg(CFG_ROW_BYTES, {2'($urandom), rb_pick});
      write_reg(CFG_ROW_COUNT, rows_pick);
      // one phase runs with both sides always ready
      idle_pct = (phase == 4) ? 0 : 20;
      void'(add_stream(1'b1));
      // last stream may stay open so the next geometry lands mid-picture
      void'(add_stream(phase == PHASES - 1 || $urandom_range(1) == 1));
      drain_and_settle();
    end

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
